// ===== rtl/core/msd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MessagePack stream decoder package
// Shared types, token kinds and the header length table.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int DEF_MAX_DEPTH = 16;

    typedef enum logic [3:0] {
        K_NIL     = 4'd0,
        K_BOOL    = 4'd1,
        K_SINT    = 4'd2,
        K_UINT    = 4'd3,
        K_F32     = 4'd4,
        K_F64     = 4'd5,
        K_RAWHDR  = 4'd6,
        K_RAWBYTE = 4'd7,
        K_ARRAY   = 4'd8,
        K_MAP     = 4'd9,
        K_ERROR   = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        C_FIXINT,
        C_FIXMAP,
        C_FIXARR,
        C_FIXSTR,
        C_NIL,
        C_BOOL,
        C_HDR,
        C_BAD
    } t_class;

    typedef struct packed {
        logic [7:0] data;
        logic       bd;
        t_class     cls;
        logic       key_ok;
        logic [3:0] hdr_left;
    } t_item;

    localparam logic [7:0] CODE_NIL = 8'hC0;

    function automatic logic [3:0] hdr_total(input logic [7:0] b);
        logic [3:0] t;
        t = 4'd0;
        unique case (b)
            8'hC4, 8'hCC, 8'hD0, 8'hD9:                 t = 4'd2;
            8'hC5, 8'hCD, 8'hD1, 8'hDA, 8'hDC, 8'hDE:   t = 4'd3;
            8'hC6, 8'hCA, 8'hCE, 8'hD2, 8'hDB, 8'hDD,
            8'hDF:                                      t = 4'd5;
            8'hCB, 8'hCF, 8'hD3:                        t = 4'd9;
            default:                                    t = 4'd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/msd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decoder front end
// Classifies each incoming byte and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module msd_front
    import msd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_begin_document,
    output logic            o_q_valid,
    output t_item           o_q_item,
    input  wire logic       i_q_pop
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic [3:0] w_total;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_total         = hdr_total(i_in_byte);
        w_item.data     = i_in_byte;
        w_item.bd       = i_begin_document;
        w_item.hdr_left = w_total - 4'd1;
        w_item.key_ok   = 1'b0;
        if (i_in_byte <= 8'h7F || i_in_byte >= 8'hE0) begin
            w_item.cls = C_FIXINT;
        end else if (i_in_byte <= 8'h8F) begin
            w_item.cls = C_FIXMAP;
        end else if (i_in_byte <= 8'h9F) begin
            w_item.cls = C_FIXARR;
        end else if (i_in_byte <= 8'hBF) begin
            w_item.cls    = C_FIXSTR;
            w_item.key_ok = 1'b1;
        end else if (i_in_byte == CODE_NIL) begin
            w_item.cls = C_NIL;
        end else if (i_in_byte == 8'hC2 || i_in_byte == 8'hC3) begin
            w_item.cls = C_BOOL;
        end else if (w_total != 4'd0) begin
            w_item.cls    = C_HDR;
            w_item.key_ok = (i_in_byte >= 8'hC4 && i_in_byte <= 8'hC6)
                         || (i_in_byte >= 8'hCC && i_in_byte <= 8'hD3)
                         || (i_in_byte >= 8'hD9 && i_in_byte <= 8'hDB);
        end else begin
            w_item.cls = C_BAD;
        end
    end

    assign full      = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign w_push    = push && !full;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/msd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decoder back end
// Parses queued bytes, tracks the nesting stack and holds the output token.
// ----------------------------------------------------------------------------
module msd_back
    import msd_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int LW        = $clog2(MAX_DEPTH + 1),
    parameter int IW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire t_item         i_q_item,
    output logic               o_q_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [3:0]         o_token_kind,
    output logic [63:0]        o_token_value,
    output logic [LW-1:0]      o_nest_depth,
    output logic               o_is_key,
    output logic               o_raw_last,
    output logic               o_doc_done
);

    typedef enum logic [2:0] {
        M_NORMAL,
        M_HEADER,
        M_RAW,
        M_DONE,
        M_ERROR
    } t_mode;

    typedef enum logic {
        S_RUN,
        S_UNWIND
    } t_state;

    typedef enum logic [2:0] {
        A_NONE,
        A_SCALAR,
        A_RAW,
        A_OPEN,
        A_FAIL
    } t_act;

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [7:0]    r_htype, n_htype;
    logic [3:0]    r_hleft, n_hleft;
    logic [63:0]   r_acc, n_acc;
    logic [31:0]   r_raw, n_raw;
    logic [LW-1:0] r_lc, n_lc;
    logic [31:0]   r_rem  [MAX_DEPTH];
    logic          r_map  [MAX_DEPTH];
    logic          r_wk   [MAX_DEPTH];

    t_kind         r_pk, n_pk;
    logic [63:0]   r_pv, n_pv;
    logic [LW-1:0] r_pd, n_pd;
    logic          r_pkey, n_pkey;
    logic          r_plast, n_plast;

    logic          r_ov, n_ov;
    t_kind         r_ok, n_ok;
    logic [63:0]   r_oval, n_oval;
    logic [LW-1:0] r_od, n_od;
    logic          r_okey, n_okey;
    logic          r_olast, n_olast;
    logic          r_odone, n_odone;

    logic          w_we;
    logic [IW-1:0] w_widx;
    logic [31:0]   w_wrem;
    logic          w_wmap;
    logic          w_wwk;

    logic          w_can_out;
    t_mode         w_mode;
    logic [LW-1:0] w_lc;
    logic [IW-1:0] w_top;
    logic          w_key;
    logic [7:0]    w_b;
    logic [63:0]   w_acc;
    t_act          w_act;
    t_kind         w_ak;
    logic [63:0]   w_av;
    logic [31:0]   w_len;
    logic          w_amap;
    logic [7:0]    w_code;
    logic          w_last;
    logic [IW-1:0] w_rtop;

    assign w_can_out = !r_ov || pop;
    assign o_q_pop   = (r_state == S_RUN) && i_q_valid && w_can_out;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_htype = r_htype;
        n_hleft = r_hleft;
        n_acc   = r_acc;
        n_raw   = r_raw;
        n_lc    = r_lc;
        n_pk    = r_pk;
        n_pv    = r_pv;
        n_pd    = r_pd;
        n_pkey  = r_pkey;
        n_plast = r_plast;
        n_ov    = r_ov && !pop;
        n_ok    = r_ok;
        n_oval  = r_oval;
        n_od    = r_od;
        n_okey  = r_okey;
        n_olast = r_olast;
        n_odone = r_odone;
        w_we    = 1'b0;
        w_widx  = '0;
        w_wrem  = '0;
        w_wmap  = 1'b0;
        w_wwk   = 1'b0;
        w_act   = A_NONE;
        w_ak    = K_NIL;
        w_av    = '0;
        w_len   = '0;
        w_amap  = 1'b0;
        w_code  = '0;
        w_last  = 1'b0;
        w_b     = i_q_item.data;
        w_acc   = {r_acc[55:0], w_b};
        w_mode  = i_q_item.bd ? M_NORMAL : r_mode;
        w_lc    = i_q_item.bd ? '0 : r_lc;
        w_top   = IW'(w_lc - LW'(1));
        w_key   = (w_lc != '0) && r_map[w_top] && r_wk[w_top];
        w_rtop  = IW'(r_lc - LW'(1));

        if (o_q_pop) begin
            n_mode = w_mode;
            n_lc   = w_lc;
            unique case (w_mode)
                M_RAW: begin
                    n_raw  = r_raw - 32'd1;
                    w_last = (n_raw == 32'd0);
                    if (w_last) begin
                        n_mode = M_NORMAL;
                        w_act  = A_SCALAR;
                    end else begin
                        n_ov    = 1'b1;
                        n_ok    = K_RAWBYTE;
                        n_oval  = {56'd0, w_b};
                        n_od    = w_lc;
                        n_okey  = w_key;
                        n_olast = 1'b0;
                        n_odone = 1'b0;
                    end
                    w_ak = K_RAWBYTE;
                    w_av = {56'd0, w_b};
                end
                M_HEADER: begin
                    n_acc   = w_acc;
                    n_hleft = (r_hleft != 4'd0) ? r_hleft - 4'd1 : 4'd0;
                    if (n_hleft == 4'd0) begin
                        n_mode = M_NORMAL;
                        w_len  = w_acc[31:0];
                        w_code = r_htype;
                        unique case (r_htype)
                            8'hCA: begin
                                w_act = A_SCALAR;
                                w_ak  = K_F32;
                                w_av  = {32'd0, w_acc[31:0]};
                            end
                            8'hCB: begin
                                w_act = A_SCALAR;
                                w_ak  = K_F64;
                                w_av  = w_acc;
                            end
                            8'hCC, 8'hCD, 8'hCE, 8'hCF: begin
                                w_act = A_SCALAR;
                                w_ak  = K_UINT;
                                w_av  = w_acc;
                            end
                            8'hD0: begin
                                w_act = A_SCALAR;
                                w_ak  = K_SINT;
                                w_av  = {{56{w_acc[7]}}, w_acc[7:0]};
                            end
                            8'hD1: begin
                                w_act = A_SCALAR;
                                w_ak  = K_SINT;
                                w_av  = {{48{w_acc[15]}}, w_acc[15:0]};
                            end
                            8'hD2: begin
                                w_act = A_SCALAR;
                                w_ak  = K_SINT;
                                w_av  = {{32{w_acc[31]}}, w_acc[31:0]};
                            end
                            8'hD3: begin
                                w_act = A_SCALAR;
                                w_ak  = K_SINT;
                                w_av  = w_acc;
                            end
                            8'hC4, 8'hC5, 8'hC6, 8'hD9, 8'hDA, 8'hDB: begin
                                w_act = A_RAW;
                            end
                            8'hDC, 8'hDD: begin
                                w_act = A_OPEN;
                            end
                            8'hDE, 8'hDF: begin
                                w_act  = A_OPEN;
                                w_amap = 1'b1;
                            end
                            default: begin
                                w_act = A_FAIL;
                            end
                        endcase
                    end
                end
                M_NORMAL: begin
                    w_code = w_b;
                    if (i_q_item.cls == C_FIXINT) begin
                        w_act = A_SCALAR;
                        w_ak  = K_SINT;
                        w_av  = {{56{w_b[7]}}, w_b};
                    end else if (w_key && !i_q_item.key_ok) begin
                        w_act = A_FAIL;
                    end else begin
                        unique case (i_q_item.cls)
                            C_FIXMAP: begin
                                w_act  = A_OPEN;
                                w_amap = 1'b1;
                                w_len  = {28'd0, w_b[3:0]};
                            end
                            C_FIXARR: begin
                                w_act = A_OPEN;
                                w_len = {28'd0, w_b[3:0]};
                            end
                            C_FIXSTR: begin
                                w_act = A_RAW;
                                w_len = {27'd0, w_b[4:0]};
                            end
                            C_NIL: begin
                                w_act = A_SCALAR;
                                w_ak  = K_NIL;
                            end
                            C_BOOL: begin
                                w_act = A_SCALAR;
                                w_ak  = K_BOOL;
                                w_av  = {63'd0, w_b[0]};
                            end
                            C_HDR: begin
                                n_mode  = M_HEADER;
                                n_htype = w_b;
                                n_hleft = i_q_item.hdr_left;
                                n_acc   = '0;
                            end
                            default: begin
                                w_act = A_FAIL;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase

            if (w_act == A_RAW) begin
                w_ak = K_RAWHDR;
                w_av = {32'd0, w_len};
                if (w_len == 32'd0) begin
                    w_act = A_SCALAR;
                end else begin
                    n_mode = M_RAW;
                    n_raw  = w_len;
                end
            end
            if (w_act == A_OPEN) begin
                w_ak = w_amap ? K_MAP : K_ARRAY;
                w_av = {32'd0, w_len};
                if (w_len == 32'd0) begin
                    w_act = A_SCALAR;
                end else if (w_lc >= LW'(MAX_DEPTH)) begin
                    w_act = A_FAIL;
                end else begin
                    w_we   = 1'b1;
                    w_widx = IW'(w_lc);
                    w_wrem = w_len - 32'd1;
                    w_wmap = w_amap;
                    w_wwk  = w_amap;
                    n_lc   = w_lc + LW'(1);
                end
            end
            if (w_act == A_FAIL) begin
                n_mode = M_ERROR;
                w_ak   = K_ERROR;
                w_av   = {56'd0, w_code};
            end

            if (w_act == A_SCALAR) begin
                n_state = S_UNWIND;
                n_pk    = w_ak;
                n_pv    = w_av;
                n_pd    = w_lc;
                n_pkey  = w_key;
                n_plast = w_last;
            end else if (w_act != A_NONE) begin
                n_ov    = 1'b1;
                n_ok    = w_ak;
                n_oval  = w_av;
                n_od    = w_lc;
                n_okey  = w_key;
                n_olast = 1'b0;
                n_odone = 1'b0;
            end
        end else if (r_state == S_UNWIND && w_can_out) begin
            n_ok    = r_pk;
            n_oval  = r_pv;
            n_od    = r_pd;
            n_okey  = r_pkey;
            n_olast = r_plast;
            n_odone = 1'b0;
            if (r_lc == '0) begin
                n_mode  = M_DONE;
                n_odone = 1'b1;
                n_ov    = 1'b1;
                n_state = S_RUN;
            end else if (r_map[w_rtop] && r_wk[w_rtop]) begin
                w_we    = 1'b1;
                w_widx  = w_rtop;
                w_wrem  = r_rem[w_rtop];
                w_wmap  = 1'b1;
                w_wwk   = 1'b0;
                n_ov    = 1'b1;
                n_state = S_RUN;
            end else if (r_rem[w_rtop] == 32'd0) begin
                n_lc = r_lc - LW'(1);
            end else begin
                w_we    = 1'b1;
                w_widx  = w_rtop;
                w_wrem  = r_rem[w_rtop] - 32'd1;
                w_wmap  = r_map[w_rtop];
                w_wwk   = r_map[w_rtop];
                n_ov    = 1'b1;
                n_state = S_RUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_rem[w_widx] <= w_wrem;
            r_map[w_widx] <= w_wmap;
            r_wk[w_widx]  <= w_wwk;
        end
        r_htype <= n_htype;
        r_hleft <= n_hleft;
        r_acc   <= n_acc;
        r_raw   <= n_raw;
        r_pk    <= n_pk;
        r_pv    <= n_pv;
        r_pd    <= n_pd;
        r_pkey  <= n_pkey;
        r_plast <= n_plast;
        r_ok    <= n_ok;
        r_oval  <= n_oval;
        r_od    <= n_od;
        r_okey  <= n_okey;
        r_olast <= n_olast;
        r_odone <= n_odone;
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_mode  <= M_NORMAL;
            r_lc    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_lc    <= n_lc;
            r_ov    <= n_ov;
        end
    end

    assign empty         = !r_ov;
    assign o_token_kind  = r_ok;
    assign o_token_value = r_oval;
    assign o_nest_depth  = r_od;
    assign o_is_key      = r_okey;
    assign o_raw_last    = r_olast;
    assign o_doc_done    = r_odone;

endmodule
`default_nettype wire

// ===== rtl/core/msgpack_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MessagePack stream decoder
// A byte is held in the front end's queue, then parsed into the back end's output
// token register. A byte that finishes a value also passes through the back end's
// stack unwinding, which closes each nesting level it ends. Other bytes go through
// at one per cycle, set by the parse step, while no token waits to be popped.
// Synchronous reset empties both queues and returns the parser to the top level.
// ----------------------------------------------------------------------------
module msgpack_stream_decoder
    import msd_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int LW        = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_begin_document,
    output logic               empty,
    input  wire logic          pop,
    output logic [3:0]         o_token_kind,
    output logic [63:0]        o_token_value,
    output logic [LW-1:0]      o_nest_depth,
    output logic               o_is_key,
    output logic               o_raw_last,
    output logic               o_doc_done
);

    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    msd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_in_byte        (i_in_byte),
        .i_begin_document (i_begin_document),
        .o_q_valid        (w_q_valid),
        .o_q_item         (w_q_item),
        .i_q_pop          (w_q_pop)
    );

    msd_back #(
        .MAX_DEPTH (MAX_DEPTH),
        .LW        (LW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_token_kind  (o_token_kind),
        .o_token_value (o_token_value),
        .o_nest_depth  (o_nest_depth),
        .o_is_key      (o_is_key),
        .o_raw_last    (o_raw_last),
        .o_doc_done    (o_doc_done)
    );

endmodule
`default_nettype wire

// ===== tb/tb_msgpack_stream_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MessagePack stream decoder testbench
// Feeds directed and random MessagePack documents byte by byte, predicts the
// token stream in a behavioral decoder and compares every popped token.
// ----------------------------------------------------------------------------
module tb_msgpack_stream_decoder
    import msd_pkg::*;
;

    localparam int DEPTH_MAX = DEF_MAX_DEPTH;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic [2:0] {
        PM_NORMAL,
        PM_HEADER,
        PM_RAW,
        PM_DONE,
        PM_ERROR
    } t_pmode;

    typedef struct packed {
        logic [7:0] data;
        logic       bd;
    } t_byte_req;

    typedef struct packed {
        t_kind      kind;
        logic [63:0] value;
        logic [4:0] depth;
        logic       key;
        logic       last;
        logic       done;
    } t_token;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_begin_document;
    logic        empty;
    logic        pop;
    logic [3:0]  o_token_kind;
    logic [63:0] o_token_value;
    logic [4:0]  o_nest_depth;
    logic        o_is_key;
    logic        o_raw_last;
    logic        o_doc_done;

    msgpack_stream_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_begin_document(i_begin_document),
        .empty           (empty),
        .pop             (pop),
        .o_token_kind    (o_token_kind),
        .o_token_value   (o_token_value),
        .o_nest_depth    (o_nest_depth),
        .o_is_key        (o_is_key),
        .o_raw_last      (o_raw_last),
        .o_doc_done      (o_doc_done)
    );

    // Decoder state for prediction.
    t_pmode      pm;
    logic [7:0]  hdr_code;
    int unsigned hdr_left;
    logic [63:0] hdr_acc;
    logic [31:0] raw_left;
    int unsigned lvl;
    logic [31:0] lvl_rem [DEPTH_MAX];
    logic        lvl_map [DEPTH_MAX];
    logic        lvl_key [DEPTH_MAX];

    t_byte_req pending_bytes[$];
    t_token    expected_tokens[$];
    int        errors = 0;
    bit        stim_done = 0;
    bit        hold_rx = 0;
    bit        hold_tx = 0;

    function automatic void clear_decoder();
        pm = PM_NORMAL;
        hdr_code = 8'h00;
        hdr_left = 0;
        hdr_acc = '0;
        raw_left = '0;
        lvl = 0;
    endfunction

    function automatic logic [63:0] sext(logic [63:0] v, int bits);
        logic [63:0] mask;
        mask = (64'd1 << bits) - 64'd1;
        v &= mask;
        if (v[bits-1]) v |= ~mask;
        return v;
    endfunction

    function automatic logic close_value();
        int unsigned t;
        forever begin
            if (lvl == 0) begin
                pm = PM_DONE;
                return 1'b1;
            end
            t = lvl - 1;
            if (lvl_map[t] && lvl_key[t]) begin
                lvl_key[t] = 1'b0;
                return 1'b0;
            end
            if (lvl_rem[t] == 0) begin
                lvl--;
                continue;
            end
            lvl_rem[t]--;
            if (lvl_map[t]) lvl_key[t] = 1'b1;
            return 1'b0;
        end
    endfunction

    function automatic void add_token(t_kind k, logic [63:0] v, int d, logic key,
                                      logic last, logic done);
        t_token tk;
        tk.kind = k;
        tk.value = v;
        tk.depth = d[4:0];
        tk.key = key;
        tk.last = last;
        tk.done = done;
        expected_tokens = {expected_tokens, tk};
    endfunction

    function automatic void add_scalar(t_kind k, logic [63:0] v, int d, logic key);
        logic done;
        done = close_value();
        add_token(k, v, d, key, 1'b0, done);
    endfunction

    function automatic void add_error(logic [7:0] code, int d, logic key);
        pm = PM_ERROR;
        add_token(K_ERROR, {56'd0, code}, d, key, 1'b0, 1'b0);
    endfunction

    function automatic void start_string(logic [31:0] len, int d, logic key);
        if (len == 0) begin
            add_scalar(K_RAWHDR, 64'd0, d, key);
        end else begin
            pm = PM_RAW;
            raw_left = len;
            add_token(K_RAWHDR, {32'd0, len}, d, key, 1'b0, 1'b0);
        end
    endfunction

    function automatic void open_level(logic is_map, logic [31:0] n, logic [7:0] code,
                                       int d, logic key);
        t_kind k;
        k = is_map ? K_MAP : K_ARRAY;
        if (n == 0) begin
            add_scalar(k, 64'd0, d, key);
        end else if (lvl >= DEPTH_MAX) begin
            add_error(code, d, key);
        end else begin
            lvl_rem[lvl] = n - 32'd1;
            lvl_map[lvl] = is_map;
            lvl_key[lvl] = is_map;
            lvl++;
            add_token(k, {32'd0, n}, d, key, 1'b0, 1'b0);
        end
    endfunction

    function automatic void complete_header(int d, logic key);
        logic [63:0] a;
        a = hdr_acc;
        pm = PM_NORMAL;
        case (hdr_code)
            8'hCA: add_scalar(K_F32, {32'd0, a[31:0]}, d, key);
            8'hCB: add_scalar(K_F64, a, d, key);
            8'hCC, 8'hCD, 8'hCE, 8'hCF: add_scalar(K_UINT, a, d, key);
            8'hD0: add_scalar(K_SINT, sext(a, 8), d, key);
            8'hD1: add_scalar(K_SINT, sext(a, 16), d, key);
            8'hD2: add_scalar(K_SINT, sext(a, 32), d, key);
            8'hD3: add_scalar(K_SINT, a, d, key);
            8'hC4, 8'hC5, 8'hC6, 8'hD9, 8'hDA, 8'hDB: start_string(a[31:0], d, key);
            8'hDC, 8'hDD: open_level(1'b0, a[31:0], hdr_code, d, key);
            8'hDE, 8'hDF: open_level(1'b1, a[31:0], hdr_code, d, key);
            default: add_error(hdr_code, d, key);
        endcase
    endfunction

    function automatic int header_length(logic [7:0] b);
        case (b)
            8'hC4, 8'hCC, 8'hD0, 8'hD9: return 2;
            8'hC5, 8'hCD, 8'hD1, 8'hDA, 8'hDC, 8'hDE: return 3;
            8'hC6, 8'hCA, 8'hCE, 8'hD2, 8'hDB, 8'hDD, 8'hDF: return 5;
            8'hCB, 8'hCF, 8'hD3: return 9;
            default: return 0;
        endcase
    endfunction

    function automatic void decode_byte(t_byte_req r);
        int   d;
        logic key;
        logic ok;
        logic last;
        logic done;
        logic [7:0] b;
        b = r.data;
        if (r.bd) clear_decoder();
        d = lvl;
        key = (lvl != 0) && lvl_map[lvl-1] && lvl_key[lvl-1];
        case (pm)
            PM_RAW: begin
                raw_left--;
                last = (raw_left == 0);
                done = 1'b0;
                if (last) begin
                    pm = PM_NORMAL;
                    done = close_value();
                end
                add_token(K_RAWBYTE, {56'd0, b}, d, key, last, done);
                return;
            end
            PM_HEADER: begin
                hdr_acc = (hdr_acc << 8) | {56'd0, b};
                if (hdr_left > 0) hdr_left--;
                if (hdr_left == 0) complete_header(d, key);
                return;
            end
            PM_NORMAL: ;
            default: return;
        endcase
        if (b <= 8'h7F || b >= 8'hE0) begin
            add_scalar(K_SINT, sext({56'd0, b}, 8), d, key);
            return;
        end
        if (key) begin
            ok = (b >= 8'hA0 && b <= 8'hBF) || (b >= 8'hC4 && b <= 8'hC6) ||
                 (b >= 8'hCC && b <= 8'hD3) || (b >= 8'hD9 && b <= 8'hDB);
            if (!ok) begin
                add_error(b, d, key);
                return;
            end
        end
        if (b <= 8'h8F) open_level(1'b1, {24'd0, 8'(b - 8'h80)}, b, d, key);
        else if (b <= 8'h9F) open_level(1'b0, {24'd0, 8'(b - 8'h90)}, b, d, key);
        else if (b <= 8'hBF) start_string({24'd0, 8'(b - 8'hA0)}, d, key);
        else if (b == CODE_NIL) add_scalar(K_NIL, 64'd0, d, key);
        else if (b == 8'hC2 || b == 8'hC3) add_scalar(K_BOOL, {63'd0, b[0]}, d, key);
        else if (header_length(b) == 0) add_error(b, d, key);
        else begin
            pm = PM_HEADER;
            hdr_code = b;
            hdr_left = header_length(b) - 1;
            hdr_acc = '0;
        end
    endfunction

    // Stimulus generation helpers.
    bit next_bd;

    function automatic void put_byte(logic [7:0] b);
        t_byte_req r;
        r.data = b;
        r.bd = next_bd;
        next_bd = 1'b0;
        pending_bytes = {pending_bytes, r};
    endfunction

    function automatic void put_wide(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) put_byte(v[8*i +: 8]);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void gen_string();
        int n;
        int sel;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 70) : $urandom_range(0, 6);
        sel = $urandom_range(0, 3);
        if (sel == 0 && n < 32) put_byte(8'(8'hA0 + n));
        else if (sel == 1) begin put_byte(8'hD9); put_byte(8'(n)); end
        else if (sel == 2) begin put_byte(8'hC5); put_wide(64'(n), 2); end
        else begin put_byte(8'hC6); put_wide(64'(n), 4); end
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void gen_int();
        case ($urandom_range(0, 9))
            0: put_byte(8'($urandom_range(0, 127)));
            1: put_byte(8'($urandom_range(224, 255)));
            2: begin put_byte(8'hCC); put_wide(rand64(), 1); end
            3: begin put_byte(8'hCD); put_wide(rand64(), 2); end
            4: begin put_byte(8'hCE); put_wide(rand64(), 4); end
            5: begin put_byte(8'hCF); put_wide(rand64(), 8); end
            6: begin put_byte(8'hD0); put_wide(rand64(), 1); end
            7: begin put_byte(8'hD1); put_wide(rand64(), 2); end
            8: begin put_byte(8'hD2); put_wide(rand64(), 4); end
            default: begin put_byte(8'hD3); put_wide(rand64(), 8); end
        endcase
    endfunction

    function automatic void gen_key();
        if ($urandom_range(0, 1) == 0) gen_string();
        else gen_int();
    endfunction

    function automatic void gen_value(int d);
        int n;
        int sel;
        sel = $urandom_range(0, 11);
        if (d >= 5 && sel >= 9) sel = $urandom_range(0, 8);
        case (sel)
            0: put_byte(CODE_NIL);
            1: put_byte(8'($urandom_range(8'hC2, 8'hC3)));
            2, 3: gen_int();
            4: begin put_byte(8'hCA); put_wide(rand64(), 4); end
            5: begin put_byte(8'hCB); put_wide(rand64(), 8); end
            6, 7, 8: gen_string();
            9: begin
                n = $urandom_range(0, 4);
                if ($urandom_range(0, 2) == 0) begin put_byte(8'hDC); put_wide(64'(n), 2); end
                else if ($urandom_range(0, 1) == 0) begin
                    put_byte(8'hDD); put_wide(64'(n), 4);
                end
                else put_byte(8'(8'h90 + n));
                for (int i = 0; i < n; i++) gen_value(d + 1);
            end
            default: begin
                n = $urandom_range(0, 3);
                if ($urandom_range(0, 2) == 0) begin put_byte(8'hDE); put_wide(64'(n), 2); end
                else if ($urandom_range(0, 1) == 0) begin
                    put_byte(8'hDF); put_wide(64'(n), 4);
                end
                else put_byte(8'(8'h80 + n));
                for (int i = 0; i < n; i++) begin
                    gen_key();
                    gen_value(d + 1);
                end
            end
        endcase
    endfunction

    // Nested arrays of one element down to the given depth, then a scalar.
    function automatic void gen_deep(int levels);
        for (int i = 0; i < levels; i++) put_byte(8'h91);
        put_byte(8'h2A);
    endfunction

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Driver: bursts with random gaps, plus a full hold-off on request.
    int gap_left = 0;
    int burst_left = 0;
    wire accepted = push && !full;

    always @(posedge i_clk) begin
        t_byte_req r;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (accepted) decode_byte({i_in_byte, i_begin_document});
            if ((accepted || !push) && gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if (accepted || !push) begin
                if (pending_bytes.size() != 0 && !hold_tx) begin
                    r = pending_bytes.pop_front();
                    push <= 1'b1;
                    i_in_byte <= r.data;
                    i_begin_document <= r.bd;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: pops on its own stall pattern and checks each token.
    int stall_phase = 0;

    always @(posedge i_clk) begin
        t_token exp_tok;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t unexpected token kind=%0d value=%h", $time,
                             o_token_kind, o_token_value);
                end else begin
                    exp_tok = expected_tokens.pop_front();
                    if (o_token_kind != exp_tok.kind || o_token_value != exp_tok.value ||
                        o_nest_depth != exp_tok.depth || o_is_key != exp_tok.key ||
                        o_raw_last != exp_tok.last || o_doc_done != exp_tok.done) begin
                        errors++;
                        $display("%0t mismatch: expected kind=%0d value=%h depth=%0d key=%b last=%b done=%b",
                                 $time, exp_tok.kind, exp_tok.value, exp_tok.depth,
                                 exp_tok.key, exp_tok.last, exp_tok.done);
                        $display("%0t            actual kind=%0d value=%h depth=%0d key=%b last=%b done=%b",
                                 $time, o_token_kind, o_token_value, o_nest_depth,
                                 o_is_key, o_raw_last, o_doc_done);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            pop <= !hold_rx && !(stall_phase < 5 && stall_phase[0]) &&
                   ($urandom_range(0, 7) != 0 || stall_phase > 15);
        end
    end

    // Watchdog on cycles without any accepted request or token.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (accepted || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        push = 1'b0;
        pop = 1'b0;
        i_in_byte = 8'h00;
        i_begin_document = 1'b0;
        i_rst_n = 1'b0;
        clear_decoder();
        next_bd = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed documents: one per special case.
        next_bd = 1'b1; put_byte(8'h00);
        next_bd = 1'b1; put_byte(8'hFF);
        next_bd = 1'b1; put_byte(8'h93); put_byte(8'h7F); put_byte(8'hE0); put_byte(8'hC3);
        next_bd = 1'b1; put_byte(8'h82); put_byte(8'hA1); put_byte(8'h41); put_byte(8'hC0);
        put_byte(8'hCC); put_byte(8'hFF); put_byte(8'hC2);
        next_bd = 1'b1; put_byte(8'hCF); put_wide(64'hFFFF_FFFF_FFFF_FFFF, 8);
        next_bd = 1'b1; put_byte(8'hD3); put_wide(64'h8000_0000_0000_0000, 8);
        next_bd = 1'b1; put_byte(8'hD1); put_wide(64'h8001, 2);
        next_bd = 1'b1; put_byte(8'hA0); put_byte(8'h11);
        next_bd = 1'b1; put_byte(8'h90);
        next_bd = 1'b1; put_byte(8'h81); put_byte(8'hC0);
        next_bd = 1'b1; put_byte(8'h81); put_byte(8'h91);
        next_bd = 1'b1; put_byte(8'hC1); put_byte(8'h01);
        next_bd = 1'b1; put_byte(8'hD4); put_byte(8'h01);
        next_bd = 1'b1; put_byte(8'hC7);
        next_bd = 1'b1; gen_deep(DEPTH_MAX);
        next_bd = 1'b1; gen_deep(DEPTH_MAX + 1);
        next_bd = 1'b1; put_byte(8'hCA); put_wide(64'h3F80_0000, 4);

        // Pause the sender until every token is out.
        wait (pending_bytes.size() == 0);
        hold_tx = 1'b1;
        wait (expected_tokens.size() == 0 && !push);
        repeat (10) @(posedge i_clk);
        hold_tx = 1'b0;

        // Random part: mostly well-formed documents, some noise.
        for (int i = 0; i < 62; i++) begin
            next_bd = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 7) == 0) begin
                for (int j = 0; j < 6; j++) put_byte(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 15) == 0) begin
                gen_deep($urandom_range(10, DEPTH_MAX + 1));
            end else begin
                gen_value(0);
            end
            if (i == 20) begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        end

        wait (pending_bytes.size() == 0 && !push);
        wait (expected_tokens.size() == 0);
        repeat (40) @(posedge i_clk);
        stim_done = 1'b1;
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
